// ----- hdl/ptad_pkg.sv -----
package ptad_pkg;

    // Team indexing
    localparam int TEAM_ID_W = 4;
    localparam int NUM_TEAMS = 2 ** TEAM_ID_W;

    // Field widths
    localparam int INFLIGHT_W = 8;
    localparam int QUANTUM_W  = 10;
    localparam int DEFICIT_W  = 13;
    localparam int STATUS_W   = 2;

    // Deficit arithmetic: wide enough for stored deficit plus one quantum
    localparam int DEF_CALC_W = DEFICIT_W + 1;
    localparam int CAP_FACTOR = 3;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 10;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PER_TEAM = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUANTUM      = 8'd1;

    localparam logic [INFLIGHT_W-1:0] MAX_PER_TEAM_RST = 8'd4;
    localparam logic [QUANTUM_W-1:0]  QUANTUM_RST      = 10'd1;

    // Request kinds
    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED     = 2'd0,
        ST_AT_CAPACITY = 2'd1,
        ST_BY_DEFICIT  = 2'd2,
        ST_RELEASED    = 2'd3
    } t_status;

endpackage

// ----- hdl/per_team_admission_deficit_core.sv -----
// Per-team admission control with a deficit rule. Each request (acquire or
// release for one of 16 teams) produces exactly one result carrying the
// status, the team's in-flight count and its signed deficit after the request.
// A request is taken into an input register and resolved, once the result
// register is empty or being read, by a read-modify-write of the per-team
// register tables into the result register. One request can be accepted every
// cycle while the output is not stalled; back-to-back requests for the same
// team see each other's updates. The result register holds its
// result under output stall while an empty input register can still take a
// request. Configuration (limit and quantum) may be written only while no
// request is pending; the write port is always ready.
module per_team_admission_deficit_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ptad_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [ptad_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Request channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_req_type,
    input  logic [ptad_pkg::TEAM_ID_W-1:0]      i_team_id,
    // Result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ptad_pkg::STATUS_W-1:0]       o_status,
    output logic [ptad_pkg::INFLIGHT_W-1:0]     o_inflight_count,
    output logic signed [ptad_pkg::DEFICIT_W-1:0] o_deficit_value
);
    import ptad_pkg::*;

    // Configuration registers
    logic [INFLIGHT_W-1:0] r_max_per_team;
    logic [QUANTUM_W-1:0]  r_quantum;

    // Per-team state
    logic [INFLIGHT_W-1:0]       r_inflight [NUM_TEAMS];
    logic signed [DEFICIT_W-1:0] r_deficit  [NUM_TEAMS];
    logic [TEAM_ID_W-1:0]        r_last_team;
    logic                        r_last_valid;

    // Input register
    logic                 r_in_valid;
    logic                 r_req_type;
    logic [TEAM_ID_W-1:0] r_team;

    // Result register
    logic                        r_out_valid;
    t_status                     r_status;
    logic [INFLIGHT_W-1:0]       r_inflight_out;
    logic signed [DEFICIT_W-1:0] r_deficit_out;

    // Resolve logic
    logic                         fire;
    logic [INFLIGHT_W-1:0]        cur_inflight;
    logic signed [DEFICIT_W-1:0]  cur_deficit;
    logic signed [DEF_CALC_W-1:0] q_s;
    logic signed [DEF_CALC_W-1:0] cap_s;
    logic signed [DEF_CALC_W-1:0] sum_s;
    logic signed [DEF_CALC_W-1:0] dec_s;
    t_status                      n_status;
    logic [INFLIGHT_W-1:0]        n_inflight;
    logic signed [DEFICIT_W-1:0]  n_deficit;
    logic                         n_grant;

    assign fire        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;

    assign cur_inflight = r_inflight[r_team];
    assign cur_deficit  = r_deficit[r_team];

    // Quantum, its cap and candidate deficits in the wider signed domain
    assign q_s   = signed'({{(DEF_CALC_W-QUANTUM_W){1'b0}}, r_quantum});
    assign cap_s = DEF_CALC_W'(CAP_FACTOR) * q_s;
    assign sum_s = DEF_CALC_W'(cur_deficit) + q_s;
    assign dec_s = DEF_CALC_W'(cur_deficit) - DEF_CALC_W'(1);

    // Decide the request against the team's current state
    always_comb begin
        n_status   = ST_RELEASED;
        n_inflight = cur_inflight;
        n_deficit  = cur_deficit;
        n_grant    = 1'b0;
        priority if (r_req_type == REQ_RELEASE) begin
            if (cur_inflight != '0) begin
                n_inflight = cur_inflight - INFLIGHT_W'(1);
            end
            if (sum_s > cap_s) begin
                n_deficit = DEFICIT_W'(cap_s);
            end else begin
                n_deficit = DEFICIT_W'(sum_s);
            end
            n_status = ST_RELEASED;
        end else if (cur_inflight >= r_max_per_team) begin
            n_status = ST_AT_CAPACITY;
        end else if (r_last_valid && (r_last_team == r_team) && cur_deficit[DEFICIT_W-1]) begin
            n_status = ST_BY_DEFICIT;
        end else begin
            if (dec_s < -q_s) begin
                n_deficit = '0;
            end else begin
                n_deficit = DEFICIT_W'(dec_s);
            end
            n_inflight = cur_inflight + INFLIGHT_W'(1);
            n_grant    = 1'b1;
            n_status   = ST_GRANTED;
        end
    end

    // Control state, tables and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_per_team <= MAX_PER_TEAM_RST;
            r_quantum      <= QUANTUM_RST;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_last_team    <= '0;
            r_last_valid   <= 1'b0;
            for (int i = 0; i < NUM_TEAMS; i++) begin
                r_inflight[i] <= '0;
                r_deficit[i]  <= '0;
            end
        end else begin
            // Take configuration writes; ignore unknown indexes
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_MAX_PER_TEAM) begin
                    r_max_per_team <= i_cfg_data[INFLIGHT_W-1:0];
                end else if (i_cfg_index == CFG_QUANTUM) begin
                    r_quantum <= i_cfg_data[QUANTUM_W-1:0];
                end
            end

            // Advance the input register
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end

            // Write back the team's state and record the last served team
            if (fire) begin
                r_inflight[r_team] <= n_inflight;
                r_deficit[r_team]  <= n_deficit;
                if (n_grant) begin
                    r_last_team  <= r_team;
                    r_last_valid <= 1'b1;
                end
            end

            // Hold or drop the result
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req_type <= i_req_type;
            r_team     <= i_team_id;
        end
        if (fire) begin
            r_status       <= n_status;
            r_inflight_out <= n_inflight;
            r_deficit_out  <= n_deficit;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_inflight_count = r_inflight_out;
    assign o_deficit_value  = r_deficit_out;

endmodule
